// File: design/trpd_pkg.sv
// shared types, constants and helpers for the touch report packet decoder
package trpd_pkg;

  localparam int ReportBytes = 7;
  localparam int IdxW = $clog2(ReportBytes + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ReportBytes);

  localparam logic [7:0] IdReset = 8'h52;
  localparam logic [7:0] KeyMark = 8'hFF;

  typedef logic [ReportBytes-1:0][7:0] report_t;

  typedef enum logic [1:0] {
    STATUS_TOUCH       = 2'd0,
    STATUS_KEY         = 2'd1,
    STATUS_ID_MISMATCH = 2'd2,
    STATUS_CHECKSUM    = 2'd3
  } status_t;

  typedef struct packed {
    logic [11:0] first_x;
    logic [11:0] first_y;
    logic [15:0] second_x;
    logic [15:0] second_y;
  } points_t;

  typedef struct packed {
    status_t     status;
    logic        touched;
    points_t     points;
    logic [7:0]  key_code;
  } result_t;

  function automatic logic [15:0] sext12(input logic [11:0] v);
    sext12 = {{4{v[11]}}, v};
  endfunction

endpackage

// File: design/trpd_eval.sv
// evaluation of a complete report: id and checksum test, key detect, point unpack
module trpd_eval (
  input  trpd_pkg::report_t  report,
  input  logic [7:0]         last_byte,
  input  logic [7:0]         sum,
  input  logic [7:0]         expected_packet_id,
  input  trpd_pkg::points_t  held,
  output trpd_pkg::result_t  result
);
  import trpd_pkg::*;

  logic        id_ok;
  logic        sum_ok;
  logic        is_key;
  logic        has_delta;
  logic [11:0] fx;
  logic [11:0] fy;
  logic [11:0] dx;
  logic [11:0] dy;
  points_t     pts;

  assign id_ok  = (report[0] == expected_packet_id);
  assign sum_ok = (last_byte == 8'(8'd0 - sum));
  assign is_key = (report[1] == KeyMark) && (report[2] == KeyMark) &&
                  (report[3] == KeyMark) && (report[4] == KeyMark) &&
                  (report[6] == KeyMark);
  assign has_delta = |{report[4], report[5], report[6]};

  assign fx = {report[1][7:4], report[2]};
  assign fy = {report[1][3:0], report[3]};
  assign dx = {report[4][7:4], report[5]};
  assign dy = {report[4][3:0], report[6]};

  always_comb begin
    pts             = held;
    result.status   = STATUS_TOUCH;
    result.key_code = 8'd0;
    if (!id_ok) begin
      result.status = STATUS_ID_MISMATCH;
    end else if (!sum_ok) begin
      result.status = STATUS_CHECKSUM;
    end else if (is_key) begin
      result.status   = STATUS_KEY;
      result.key_code = report[5];
    end else begin
      pts.first_x = fx;
      pts.first_y = fy;
      // second point, if any delta byte is nonzero, is absolute first point plus signed delta, mod 2^16; else held
      if (has_delta) begin
        pts.second_x = {4'd0, fx} + sext12(dx);
        pts.second_y = {4'd0, fy} + sext12(dy);
      end
    end
    result.points  = pts;
    result.touched = (result.status == STATUS_TOUCH || result.status == STATUS_KEY) &&
                     (|{pts.first_x, pts.first_y, pts.second_x, pts.second_y});
  end

endmodule

// File: design/touch_report_packet_decoder.sv
// top level of the touch report packet decoder
// a result is registered in the output register once the eighth byte has moved through the input
//   register and the output register is free (out_valid low or out_ready high)
// throughput: one byte per cycle; while a result waits, bytes still enter until a report's last byte stalls
// reset (rst, synchronous): valid flags, byte counter, running sum, held points cleared, id back to 0x52
module touch_report_packet_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        packet_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic        touched,
  output logic [11:0] first_x,
  output logic [11:0] first_y,
  output logic [15:0] second_x,
  output logic [15:0] second_y,
  output logic [7:0]  key_code
);
  import trpd_pkg::*;

  logic            in_q_valid;
  logic [7:0]      byte_q;
  logic            start_q;
  logic [7:0]      expected_packet_id;
  logic [IdxW-1:0] byte_index;
  logic [7:0]      running_sum;
  report_t         report_bytes;
  points_t         held;
  result_t         result;

  logic [IdxW-1:0] idx_eff;
  logic [7:0]      sum_eff;
  logic            is_last;
  logic            advance;

  assign idx_eff = start_q ? '0 : byte_index;
  assign sum_eff = start_q ? 8'd0 : running_sum;
  assign is_last = (idx_eff == LastIdx);
  // a byte that ends a report needs the output register free
  assign advance  = in_q_valid && (!is_last || !out_valid || out_ready);
  assign in_ready = !in_q_valid || advance;

  trpd_eval u_eval (
    .report             (report_bytes),
    .last_byte          (byte_q),
    .sum                (sum_eff),
    .expected_packet_id (expected_packet_id),
    .held               (held),
    .result             (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_packet_id <= IdReset;
    end else if (cfg_we) begin
      expected_packet_id <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_q  <= data_byte;
      start_q <= packet_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index  <= '0;
      running_sum <= 8'd0;
      held        <= '0;
    end else if (advance) begin
      if (is_last) begin
        byte_index  <= '0;
        running_sum <= 8'd0;
        held        <= result.points;
      end else begin
        byte_index  <= idx_eff + 1'b1;
        running_sum <= sum_eff + byte_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ReportBytes; i++) begin
      if (advance && !is_last && idx_eff == IdxW'(i)) begin
        report_bytes[i] <= byte_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && is_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_last) begin
      status   <= result.status;
      touched  <= result.touched;
      first_x  <= result.points.first_x;
      first_y  <= result.points.first_y;
      second_x <= result.points.second_x;
      second_y <= result.points.second_y;
      key_code <= result.key_code;
    end
  end

  a_touched_valid_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && touched |-> (status == STATUS_TOUCH || status == STATUS_KEY))
    else $error("touched set on a rejected report");

  a_key_code_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_KEY |-> key_code == 8'd0)
    else $error("key code reported outside a key packet");

  a_result_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_q_valid && !start_q && byte_index == LastIdx))
    else $error("result produced without a final byte");

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the touch report packet decoder
`timescale 1ns / 1ps

module tb_top;
  import trpd_pkg::*;

  localparam int StallLimit = 2000;
  localparam int HoldCycles = 300;

  typedef logic [1:6][7:0] body_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        packet_start;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic        touched;
  logic [11:0] first_x;
  logic [11:0] first_y;
  logic [15:0] second_x;
  logic [15:0] second_y;
  logic [7:0]  key_code;

  // decoder model state
  logic [7:0]  cur_pid;
  logic [2:0]  byte_pos;
  logic [7:0]  byte_sum;
  logic [7:0]  report_buf [0:6];
  logic [11:0] held_fx;
  logic [11:0] held_fy;
  logic [15:0] held_sx;
  logic [15:0] held_sy;

  result_t pending_reports [$];
  int      mismatches;
  int      bytes_sent;
  int      idle_cycles;
  bit      sender_gaps;
  bit      tail_mode;
  bit      hold_req;

  touch_report_packet_decoder u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .packet_start (packet_start),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .touched      (touched),
    .first_x      (first_x),
    .first_y      (first_y),
    .second_x     (second_x),
    .second_y     (second_y),
    .key_code     (key_code)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // advance the model by one accepted byte; returns 1 when a report is due
  function automatic bit decode_byte(input logic [7:0] b, input logic s, output result_t r);
    logic [11:0] dx;
    logic [11:0] dy;
    logic [7:0]  neg_sum;
    logic [7:0]  key;
    status_t     st;
    r = '0;
    key = 8'd0;
    if (s) begin
      byte_pos = 3'd0;
      byte_sum = 8'd0;
    end
    if (byte_pos < 3'd7) begin
      report_buf[byte_pos] = b;
      byte_sum = byte_sum + b;
      byte_pos = byte_pos + 3'd1;
      return 1'b0;
    end
    byte_pos = 3'd0;
    neg_sum = 8'd0 - byte_sum;
    if (report_buf[0] != cur_pid) begin
      st = STATUS_ID_MISMATCH;
    end else if (b != neg_sum) begin
      st = STATUS_CHECKSUM;
    end else if (report_buf[1] == KeyMark && report_buf[2] == KeyMark &&
                 report_buf[3] == KeyMark && report_buf[4] == KeyMark &&
                 report_buf[6] == KeyMark) begin
      st = STATUS_KEY;
      key = report_buf[5];
    end else begin
      st = STATUS_TOUCH;
      held_fx = {report_buf[1][7:4], report_buf[2]};
      held_fy = {report_buf[1][3:0], report_buf[3]};
      if (|{report_buf[4], report_buf[5], report_buf[6]}) begin
        dx = {report_buf[4][7:4], report_buf[5]};
        dy = {report_buf[4][3:0], report_buf[6]};
        held_sx = {4'd0, held_fx} + {{4{dx[11]}}, dx};
        held_sy = {4'd0, held_fy} + {{4{dy[11]}}, dy};
      end
    end
    byte_sum = 8'd0;
    r.status = st;
    r.touched = (st == STATUS_TOUCH || st == STATUS_KEY) &&
                (|{held_fx, held_fy, held_sx, held_sy});
    r.points.first_x = held_fx;
    r.points.first_y = held_fy;
    r.points.second_x = held_sx;
    r.points.second_y = held_sy;
    r.key_code = key;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endfunction

  // one request on the input channel, valid left high after acceptance
  task automatic send_byte(input logic [7:0] b, input logic s);
    result_t r;
    if (sender_gaps && !tail_mode && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 8)) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    data_byte = b;
    packet_start = s;
    do @(posedge clk); while (!in_ready);
    if (decode_byte(b, s, r)) pending_reports.push_back(r);
    bytes_sent++;
  endtask

  task automatic send_report(input logic [7:0] id, input body_t body, input bit corrupt,
                             input bit mark_start);
    logic [7:0] total;
    logic [7:0] csum;
    total = id;
    for (int i = 1; i <= 6; i++) total = total + body[i];
    csum = 8'd0 - total;
    if (corrupt) csum = csum ^ 8'($urandom_range(1, 255));
    send_byte(id, mark_start);
    for (int i = 1; i <= 6; i++) send_byte(body[i], 1'b0);
    send_byte(csum, 1'b0);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    // let a trailing byte clear the input register
    repeat (4) @(posedge clk);
  endtask

  task automatic write_pid(input logic [7:0] v);
    @(negedge clk);
    in_valid = 1'b0;
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    cur_pid = v;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random_report();
    int     kind;
    int     n;
    body_t  body;
    logic [7:0] id;
    kind = $urandom_range(0, 99);
    sender_gaps = ($urandom_range(0, 3) != 0);
    id = (kind < 8) ? 8'($urandom_range(0, 255)) : cur_pid;
    for (int i = 1; i <= 6; i++) body[i] = pick_byte();
    if ($urandom_range(0, 4) == 0) begin
      body[4] = 8'h00;
      body[5] = 8'h00;
      body[6] = 8'h00;
    end
    if (kind >= 8 && kind < 23) begin
      body[1] = KeyMark;
      body[2] = KeyMark;
      body[3] = KeyMark;
      body[4] = KeyMark;
      body[6] = KeyMark;
      case ($urandom_range(0, 3))
        0: body[5] = 8'h01;
        1: body[5] = 8'h02;
        2: body[5] = 8'h04;
        default: body[5] = 8'($urandom_range(0, 255));
      endcase
    end
    if (kind >= 90 && kind < 95) begin
      // loose bytes with random framing
      n = $urandom_range(1, 4);
      repeat (n) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) < 3);
    end else if (kind >= 95) begin
      // truncated report, then a fresh one
      n = $urandom_range(1, 7);
      send_byte(cur_pid, 1'b1);
      repeat (n - 1) send_byte(pick_byte(), 1'b0);
      send_report(id, body, $urandom_range(0, 9) == 0, 1'b1);
    end else begin
      send_report(id, body, $urandom_range(0, 9) == 0, $urandom_range(0, 19) != 0);
    end
  endtask

  task automatic test_touch();
    sender_gaps = 1'b1;
    // all zero: touched stays low
    send_report(IdReset, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 1'b1);
    // max coordinates, largest positive delta
    send_report(IdReset, {8'hFF, 8'hFF, 8'hFF, 8'h77, 8'hFF, 8'hFF}, 1'b0, 1'b1);
    // negative delta wrapping below zero
    send_report(IdReset, {8'h00, 8'h01, 8'h00, 8'hF8, 8'h05, 8'h00}, 1'b0, 1'b1);
  endtask

  task automatic test_key();
    send_report(IdReset, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h04, 8'hFF}, 1'b0, 1'b1);
  endtask

  task automatic test_id_mismatch();
    // checksum also wrong, must not matter
    send_report(8'h53, {8'h12, 8'h34, 8'h56, 8'h00, 8'h00, 8'h00}, 1'b1, 1'b1);
  endtask

  task automatic test_checksum();
    send_report(IdReset, {8'h12, 8'h34, 8'h56, 8'h00, 8'h00, 8'h00}, 1'b1, 1'b1);
  endtask

  task automatic test_framing();
    // early start drops the partial report
    send_byte(IdReset, 1'b1);
    send_byte(8'h21, 1'b0);
    send_byte(8'h43, 1'b0);
    send_report(IdReset, {8'h12, 8'h34, 8'h56, 8'h00, 8'h00, 8'h00}, 1'b0, 1'b1);
    // no start mark, counter already wrapped
    send_report(IdReset, {8'hA5, 8'h5A, 8'hC3, 8'h00, 8'h01, 8'h00}, 1'b0, 1'b0);
  endtask

  task automatic test_random_traffic(input int n_bytes, input logic [7:0] pid);
    int target;
    wait_drain();
    write_pid(pid);
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) send_random_report();
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    sender_gaps = 1'b0;
    repeat (6) send_report(cur_pid, {pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                                     pick_byte(), pick_byte()}, 1'b0, 1'b1);
  endtask

  task automatic test_drain_pause();
    repeat (3) send_random_report();
    wait_drain();
    repeat (3) send_random_report();
  endtask

  task automatic test_tail(input int n_bytes);
    int target;
    tail_mode = 1'b1;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) send_random_report();
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected report, expected none actual status %0d", $time, status);
      end else begin
        want = pending_reports.pop_front();
        check_field("status", want.status, status);
        check_field("touched", want.touched, touched);
        check_field("first_x", want.points.first_x, first_x);
        check_field("first_y", want.points.first_y, first_y);
        check_field("second_x", want.points.second_x, second_x);
        check_field("second_y", want.points.second_y, second_y);
        check_field("key_code", want.key_code, key_code);
      end
    end
  end

  // receiver: random stall bursts, plus one long hold on request
  initial begin : receiver
    int n;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (!tail_mode && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        n = $urandom_range(1, 9);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // watchdog on cycles with no request moving
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("touch_report_packet_decoder verification failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 8'd0;
    in_valid = 1'b0;
    data_byte = 8'd0;
    packet_start = 1'b0;
    hold_req = 1'b0;
    tail_mode = 1'b0;
    sender_gaps = 1'b1;
    mismatches = 0;
    bytes_sent = 0;
    idle_cycles = 0;
    cur_pid = IdReset;
    byte_pos = 3'd0;
    byte_sum = 8'd0;
    for (int i = 0; i < 7; i++) report_buf[i] = 8'd0;
    held_fx = 12'd0;
    held_fy = 12'd0;
    held_sx = 16'd0;
    held_sy = 16'd0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    test_touch();
    test_key();
    test_id_mismatch();
    test_checksum();
    test_framing();
    test_random_traffic(200, 8'h00);
    test_random_traffic(200, 8'hFF);
    test_random_traffic(200, 8'($urandom_range(1, 254)));
    test_random_traffic(200, IdReset);
    test_backpressure();
    test_drain_pause();
    test_tail(120);

    wait_drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("touch_report_packet_decoder verification clean");
    end else begin
      $display("touch_report_packet_decoder verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
design/trpd_pkg.sv
design/trpd_eval.sv
design/touch_report_packet_decoder.sv
tb/tb_top.sv
